// ----- rtl/core/sae_pkg.sv -----
// Shared types and constants for the stack ALU engine.
package sae_pkg;

  // Default number of stack entries.
  localparam int STACK_DEPTH_DEF = 256;

  // Width of one data word and of the iteration counter of the shared unit.
  localparam int DATA_W = 32;
  localparam int STEP_W = 5;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DATA_W - 1);

  // Width of the reported depth field.
  localparam int DEPTH_FIELD_W = 9;

  // Request codes.
  typedef enum logic [2:0] {
    REQ_NOP  = 3'd0,
    REQ_PUSH = 3'd1,
    REQ_POP  = 3'd2,
    REQ_PEEK = 3'd3,
    REQ_ADD  = 3'd4,
    REQ_SUB  = 3'd5,
    REQ_MUL  = 3'd6,
    REQ_DIV  = 3'd7
  } req_t;

  // Error codes.
  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_FEW  = 2'd1,
    ERR_DIV0 = 2'd2,
    ERR_FULL = 2'd3
  } err_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_RD_TOP,
    S_RD_SEC,
    S_RUN
  } state_t;

  // States of the shared arithmetic unit.
  typedef enum logic [1:0] {
    U_IDLE,
    U_ONE,
    U_LOOP,
    U_FIX
  } alu_state_t;

  // Control from the sequencer to the shared unit.
  typedef struct packed {
    logic start;
    req_t op;
  } alu_ctrl_t;

endpackage

// ----- rtl/core/sae_alu.sv -----
// Shared arithmetic unit: one adder used for add, subtract, shift-add multiply and divide.
module sae_alu (
  input  logic                             clk,
  input  logic                             rst,
  input  sae_pkg::alu_ctrl_t               ctrl,
  input  logic [sae_pkg::DATA_W-1:0]       opnd_s,
  input  logic [sae_pkg::DATA_W-1:0]       opnd_t,
  output logic                             done,
  output logic [sae_pkg::DATA_W-1:0]       result
);

  localparam int W = sae_pkg::DATA_W;

  sae_pkg::alu_state_t state, state_next;
  sae_pkg::req_t       op;
  logic [W-1:0]        acc;
  logic [W-1:0]        ra;
  logic [W-1:0]        rb;
  logic [sae_pkg::STEP_W-1:0] step;
  logic                neg;

  logic [W:0]   add_a;
  logic [W:0]   add_b;
  logic         add_sub;
  logic [W:0]   sum;
  logic [W:0]   shifted;
  logic [W-1:0] mag_s;
  logic [W-1:0] mag_t;

  // Magnitudes of the division operands.
  assign mag_s = opnd_s[W-1] ? (~opnd_s + 1'b1) : opnd_s;
  assign mag_t = opnd_t[W-1] ? (~opnd_t + 1'b1) : opnd_t;

  // Partial remainder shifted left by one, taking the next dividend bit.
  assign shifted = {acc, ra[W-1]};

  // The one shared adder.
  assign sum = add_a + (add_b ^ {(W+1){add_sub}}) + {{W{1'b0}}, add_sub};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sae_pkg::U_IDLE: begin
        if (ctrl.start) begin
          unique case (ctrl.op) inside
            sae_pkg::REQ_ADD, sae_pkg::REQ_SUB: state_next = sae_pkg::U_ONE;
            sae_pkg::REQ_MUL, sae_pkg::REQ_DIV: state_next = sae_pkg::U_LOOP;
            default:                            state_next = sae_pkg::U_IDLE;
          endcase
        end
      end
      sae_pkg::U_ONE:  state_next = sae_pkg::U_IDLE;
      sae_pkg::U_LOOP: begin
        if (step == sae_pkg::STEP_LAST) begin
          state_next = sae_pkg::U_FIX;
        end
      end
      sae_pkg::U_FIX:  state_next = sae_pkg::U_IDLE;
      default:         state_next = sae_pkg::U_IDLE;
    endcase
  end

  // Adder operand selection.
  always_comb begin
    add_a   = {1'b0, ra};
    add_b   = {1'b0, rb};
    add_sub = 1'b0;
    unique case (state)
      sae_pkg::U_ONE: begin
        add_sub = (op == sae_pkg::REQ_SUB);
      end
      sae_pkg::U_LOOP: begin
        if (op == sae_pkg::REQ_DIV) begin
          add_a   = shifted;
          add_b   = {1'b0, rb};
          add_sub = 1'b1;
        end else begin
          add_a   = {1'b0, acc};
          add_b   = {1'b0, rb & {W{ra[0]}}};
          add_sub = 1'b0;
        end
      end
      default: begin
        add_a   = {1'b0, ra};
        add_b   = {1'b0, rb};
        add_sub = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sae_pkg::U_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == sae_pkg::U_ONE) || (state == sae_pkg::U_FIX);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      sae_pkg::U_IDLE: begin
        if (ctrl.start) begin
          op   <= ctrl.op;
          acc  <= '0;
          step <= '0;
          neg  <= opnd_s[W-1] ^ opnd_t[W-1];
          if (ctrl.op == sae_pkg::REQ_DIV) begin
            ra <= mag_s;
            rb <= mag_t;
          end else begin
            ra <= opnd_s;
            rb <= opnd_t;
          end
        end
      end
      sae_pkg::U_ONE: begin
        result <= sum[W-1:0];
      end
      sae_pkg::U_LOOP: begin
        step <= step + 1'b1;
        if (op == sae_pkg::REQ_DIV) begin
          // Restoring step: keep the difference when it did not go negative.
          if (!sum[W]) begin
            acc <= sum[W-1:0];
            ra  <= {ra[W-2:0], 1'b1};
          end else begin
            acc <= shifted[W-1:0];
            ra  <= {ra[W-2:0], 1'b0};
          end
        end else begin
          // Shift-add step: multiplier moves right, multiplicand left.
          acc <= sum[W-1:0];
          ra  <= {1'b0, ra[W-1:1]};
          rb  <= {rb[W-2:0], 1'b0};
        end
      end
      sae_pkg::U_FIX: begin
        if (op == sae_pkg::REQ_DIV) begin
          result <= neg ? (~ra + 1'b1) : ra;
        end else begin
          result <= acc;
        end
      end
      default: begin
        result <= result;
      end
    endcase
  end

endmodule

// ----- rtl/core/stack_alu_engine.sv -----
// Top level of the stack ALU engine: operand stack, sequencer and response registers.
//
//  Channel   | Handshake               | Payload
//  ----------+-------------------------+------------------------------------------------
//  request   | start, busy             | req_type, push_value
//  response  | done (one-cycle strobe) | result_value, error_code, stack_empty, stack_depth
//
// A nop, a push, or a request refused for too few operands or a full stack ends in S_CHECK,
// a pop or peek in S_RD_TOP, a division by zero in S_RD_SEC, and arithmetic in S_RUN when
// sae_alu reports done; multiply and divide iterate its shared adder over every data bit.
// Busy is high in every cycle between acceptance and done and low in the cycle of done, so
// the next request can be taken at the edge that ends it. Reset clears the depth and the
// sequencer, not the stack contents; there are no stalls.
module stack_alu_engine #(
  parameter int STACK_DEPTH = sae_pkg::STACK_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [2:0]                        req_type,
  input  logic signed [31:0]                push_value,
  output logic                              done,
  output logic signed [31:0]                result_value,
  output logic [1:0]                        error_code,
  output logic                              stack_empty,
  output logic [8:0]                        stack_depth
);

  localparam int W     = sae_pkg::DATA_W;
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int DF_W  = sae_pkg::DEPTH_FIELD_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

  sae_pkg::state_t state, state_next;
  sae_pkg::req_t   req;
  logic [W-1:0]    pval;
  logic [W-1:0]    op_t;
  logic [CNT_W-1:0] count, count_next;

  // Stack memory.
  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rdata;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;

  // Response assembly.
  logic          resp_fire;
  logic [W-1:0]  resp_value;
  sae_pkg::err_t resp_err;
  logic          op_t_load;

  // Shared unit connection.
  sae_pkg::alu_ctrl_t alu_ctrl;
  logic               alu_done;
  logic [W-1:0]       alu_result;

  logic [CNT_W-1:0]      count_m1;
  logic [CNT_W-1:0]      count_m2;
  logic [CNT_W+DF_W-1:0] depth_ext;

  assign count_m1  = count - 1'b1;
  assign count_m2  = count - 2'd2;
  assign depth_ext = {{DF_W{1'b0}}, count_next};
  assign busy      = (state != sae_pkg::S_IDLE);

  sae_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .ctrl   (alu_ctrl),
    .opnd_s (rdata),
    .opnd_t (op_t),
    .done   (alu_done),
    .result (alu_result)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      sae_pkg::S_IDLE: begin
        if (start) begin
          state_next = sae_pkg::S_CHECK;
        end
      end
      sae_pkg::S_CHECK: begin
        unique case (req) inside
          sae_pkg::REQ_NOP, sae_pkg::REQ_PUSH: begin
            state_next = sae_pkg::S_IDLE;
          end
          sae_pkg::REQ_POP, sae_pkg::REQ_PEEK: begin
            state_next = (count == '0) ? sae_pkg::S_IDLE : sae_pkg::S_RD_TOP;
          end
          default: begin
            state_next = (count < CNT_W'(2)) ? sae_pkg::S_IDLE : sae_pkg::S_RD_TOP;
          end
        endcase
      end
      sae_pkg::S_RD_TOP: begin
        if ((req == sae_pkg::REQ_POP) || (req == sae_pkg::REQ_PEEK)) begin
          state_next = sae_pkg::S_IDLE;
        end else begin
          state_next = sae_pkg::S_RD_SEC;
        end
      end
      sae_pkg::S_RD_SEC: begin
        if ((req == sae_pkg::REQ_DIV) && (op_t == '0)) begin
          state_next = sae_pkg::S_IDLE;
        end else begin
          state_next = sae_pkg::S_RUN;
        end
      end
      sae_pkg::S_RUN: begin
        if (alu_done) begin
          state_next = sae_pkg::S_IDLE;
        end
      end
      default: state_next = sae_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    count_next    = count;
    raddr         = count_m1[AW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = count[AW-1:0];
    mem_wdata     = pval;
    resp_fire     = 1'b0;
    resp_value    = '0;
    resp_err      = sae_pkg::ERR_OK;
    op_t_load     = 1'b0;
    alu_ctrl      = '{start: 1'b0, op: req};
    unique case (state)
      sae_pkg::S_IDLE: begin
      end
      sae_pkg::S_CHECK: begin
        unique case (req) inside
          sae_pkg::REQ_NOP: begin
            resp_fire = 1'b1;
          end
          sae_pkg::REQ_PUSH: begin
            resp_fire = 1'b1;
            if (count == CNT_FULL) begin
              resp_err = sae_pkg::ERR_FULL;
            end else begin
              mem_we     = 1'b1;
              count_next = count + 1'b1;
              resp_value = pval;
            end
          end
          sae_pkg::REQ_POP, sae_pkg::REQ_PEEK: begin
            if (count == '0) begin
              resp_fire = 1'b1;
              resp_err  = sae_pkg::ERR_FEW;
            end
          end
          default: begin
            if (count < CNT_W'(2)) begin
              resp_fire = 1'b1;
              resp_err  = sae_pkg::ERR_FEW;
            end
          end
        endcase
      end
      sae_pkg::S_RD_TOP: begin
        // Top entry is on the read port; fetch the second one for arithmetic.
        op_t_load = 1'b1;
        raddr     = count_m2[AW-1:0];
        if ((req == sae_pkg::REQ_POP) || (req == sae_pkg::REQ_PEEK)) begin
          resp_fire  = 1'b1;
          resp_value = rdata;
          if (req == sae_pkg::REQ_POP) begin
            count_next = count_m1;
          end
        end
      end
      sae_pkg::S_RD_SEC: begin
        if ((req == sae_pkg::REQ_DIV) && (op_t == '0)) begin
          resp_fire = 1'b1;
          resp_err  = sae_pkg::ERR_DIV0;
        end else begin
          alu_ctrl.start = 1'b1;
        end
      end
      sae_pkg::S_RUN: begin
        mem_waddr = count_m2[AW-1:0];
        mem_wdata = alu_result;
        if (alu_done) begin
          mem_we     = 1'b1;
          count_next = count_m1;
          resp_fire  = 1'b1;
          resp_value = alu_result;
        end
      end
      default: begin
      end
    endcase
  end

  // Stack memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[raddr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sae_pkg::S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= resp_fire;
    end
  end

  // Request capture, top operand and response payload.
  always_ff @(posedge clk) begin
    if ((state == sae_pkg::S_IDLE) && start) begin
      req  <= sae_pkg::req_t'(req_type);
      pval <= push_value;
    end
    if (op_t_load) begin
      op_t <= rdata;
    end
    if (resp_fire) begin
      result_value <= resp_value;
      error_code   <= resp_err;
      stack_empty  <= (count_next == '0);
      stack_depth  <= depth_ext[DF_W-1:0];
    end
  end

endmodule
